@@ sv/kplc_pkg.sv @@
`default_nettype none
package kplc_pkg;

	localparam int KEY_LINES        = 16;
	localparam int MAX_BUFFER_DEPTH = 16;
	localparam int CODE_W           = 16;
	localparam int CHAR_W           = 7;
	localparam int POS_W            = 5;
	localparam int CFG_INDEX_W      = 1;
	localparam int CFG_DATA_W       = 16;

	localparam logic [CODE_W-1:0] RELEASED_CODE = 16'hFFFF;
	localparam logic [CODE_W-1:0] HOLD_MAX      = 16'hFFFF;
	localparam logic [CODE_W-1:0] THRESHOLD_RST = 16'd140;
	localparam logic [POS_W-1:0]  DEPTH_RST     = 5'd13;

	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH     = 1'd1;

	localparam logic [1:0] STATUS_NONE    = 2'd0;
	localparam logic [1:0] STATUS_SHORT   = 2'd1;
	localparam logic [1:0] STATUS_LONG    = 2'd2;
	localparam logic [1:0] STATUS_NO_HOLD = 2'd3;

	localparam logic [CODE_W-1:0] KEY_PATTERNS [KEY_LINES] = '{
		16'hFFFE, 16'hFFFD, 16'hFFFB, 16'hFFEF, 16'hFFDF, 16'hFFBF, 16'hFEFF, 16'hFDFF,
		16'hFBFF, 16'hEFFF, 16'hDFFF, 16'hBFFF, 16'h7FFF, 16'hF7FF, 16'hFF7F, 16'hFFF7
	};
	localparam logic [CHAR_W-1:0] KEY_NAMES [KEY_LINES] = '{
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h2A, 7'h30, 7'h23, 7'h44, 7'h43, 7'h42, 7'h41
	};

	typedef struct packed {
		logic              mode;
		logic [CODE_W-1:0] key_bits;
	} scan_t;

	typedef struct packed {
		logic [CHAR_W-1:0] key_char;
		logic              beep_on;
		logic [1:0]        press_status;
		logic [CHAR_W-1:0] event_char;
		logic [CODE_W-1:0] event_code;
		logic [POS_W-1:0]  buffer_pos;
		logic              buffer_wrapped;
	} result_t;

	typedef struct packed {
		logic              hit;
		logic [CHAR_W-1:0] name;
	} decode_t;

endpackage
`default_nettype wire

@@ sv/kplc_stream_if.sv @@
`default_nettype none
interface kplc_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/kplc_cfg_if.sv @@
`default_nettype none
interface kplc_cfg_if
	import kplc_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ sv/keypad_press_length_classifier.sv @@
// the result item for an accepted scan item is registered and offered on result in the cycle after acceptance
// throughput: one item per cycle while result.ready holds, a new item is taken while the result register drains
// the hold counter and buffer position update in a single registered pass per item
// reset (arst_n low, asynchronous): threshold 140, depth 13, all key and hold state zero
`default_nettype none
module keypad_press_length_classifier
	import kplc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	kplc_cfg_if.sink                   cfg,
	kplc_stream_if.sink                scan,
	kplc_stream_if.source              result
);

	logic [CODE_W-1:0] threshold_q;
	logic [POS_W-1:0]  depth_q;
	logic [CODE_W-1:0] prev_code_q, cur_code_q, hold_q;
	logic [CHAR_W-1:0] prev_char_q, cur_char_q;
	logic [POS_W-1:0]  wr_pos_q;
	logic              wrap_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              accept;
	decode_t           dec;
	scan_t             item;
	logic [POS_W-1:0]  depth_use;
	logic [CODE_W-1:0] prev_code_n, cur_code_n, hold_n;
	logic [CHAR_W-1:0] prev_char_n, cur_char_n;
	logic [POS_W-1:0]  wr_pos_n;
	logic              wrap_n;
	logic              classify;
	logic [CHAR_W-1:0] cls_char;
	logic [CODE_W-1:0] cls_code;
	result_t           res;

	assign item         = scan.data;
	assign scan.ready   = !out_valid_q || result.ready;
	assign accept       = scan.valid && scan.ready;
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	kplc_key_decoder u_dec (
		.key_bits (item.key_bits),
		.dec      (dec)
	);

	always_comb begin
		if (depth_q == '0) begin
			depth_use = POS_W'(1);
		end else if (int'(depth_q) > MAX_BUFFER_DEPTH) begin
			depth_use = POS_W'(MAX_BUFFER_DEPTH);
		end else begin
			depth_use = depth_q;
		end
	end

	always_comb begin
		prev_code_n = prev_code_q;
		prev_char_n = prev_char_q;
		cur_code_n  = cur_code_q;
		cur_char_n  = cur_char_q;
		hold_n      = hold_q;
		wr_pos_n    = wr_pos_q;
		wrap_n      = wrap_q;
		classify    = 1'b0;
		cls_char    = cur_char_q;
		cls_code    = cur_code_q;
		res         = '0;

		if (item.mode) begin
			classify = 1'b1;
		end else begin
			cur_code_n = item.key_bits;
			if (dec.hit) begin
				cur_char_n = dec.name;
			end
			if (item.key_bits == RELEASED_CODE) begin
				classify = 1'b1;
				cls_char = prev_char_q;
				cls_code = prev_code_q;
			end else begin
				if (item.key_bits == prev_code_q) begin
					if (hold_q != HOLD_MAX) begin
						hold_n = hold_q + 1'b1;
					end
					res.beep_on = 1'b1;
				end else begin
					hold_n = '0;
				end
				prev_code_n = item.key_bits;
				prev_char_n = cur_char_n;
			end
		end

		if (classify) begin
			if (hold_q == '0) begin
				res.press_status = STATUS_NO_HOLD;
			end else begin
				hold_n         = '0;
				res.event_char = cls_char;
				res.event_code = cls_code;
				if (hold_q < threshold_q) begin
					res.press_status = STATUS_SHORT;
					if (wr_pos_q >= depth_use) begin
						wr_pos_n = POS_W'(1);
						wrap_n   = 1'b1;
					end else begin
						wr_pos_n = wr_pos_q + 1'b1;
					end
				end else begin
					res.press_status = STATUS_LONG;
				end
			end
		end

		res.key_char       = cur_char_n;
		res.buffer_pos     = wr_pos_n;
		res.buffer_wrapped = wrap_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			depth_q     <= DEPTH_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_THRESHOLD: threshold_q <= cfg.wdata;
				CFG_DEPTH:     depth_q     <= cfg.wdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_code_q <= '0;
			prev_char_q <= '0;
			cur_code_q  <= '0;
			cur_char_q  <= '0;
			hold_q      <= '0;
			wr_pos_q    <= '0;
			wrap_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				prev_code_q <= prev_code_n;
				prev_char_q <= prev_char_n;
				cur_code_q  <= cur_code_n;
				cur_char_q  <= cur_char_n;
				hold_q      <= hold_n;
				wr_pos_q    <= wr_pos_n;
				wrap_q      <= wrap_n;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire

@@ sv/kplc_key_decoder.sv @@
`default_nettype none
module kplc_key_decoder
	import kplc_pkg::*;
(
	input  wire logic [CODE_W-1:0] key_bits,
	output decode_t                dec
);

	always_comb begin
		dec.hit  = 1'b0;
		dec.name = '0;
		for (int i = 0; i < KEY_LINES; i++) begin
			if (KEY_PATTERNS[i] == key_bits) begin
				dec.hit  = 1'b1;
				dec.name = KEY_NAMES[i];
			end
		end
	end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
module tb;
	import kplc_pkg::*;

	localparam logic MODE_SCAN    = 1'b0;
	localparam logic MODE_TIMEOUT = 1'b1;
	localparam int   STALL_LIMIT  = 3000;
	localparam int   SINK_HOLDOFF = 400;

	class press_tracker;
		bit [15:0] threshold = 16'd140;
		bit [4:0]  depth     = 5'd13;
		bit [15:0] last_code;
		bit [6:0]  last_char;
		bit [15:0] cur_code;
		bit [6:0]  cur_char;
		bit [15:0] hold;
		bit [4:0]  wpos;
		bit        wrapped;
		result_t   outcome_q[$];
		int        mismatches;

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
			if (idx == CFG_THRESHOLD) begin
				threshold = val;
			end else if (idx == CFG_DEPTH) begin
				depth = val[4:0];
			end
		endfunction

		function bit [6:0] pattern_char(bit [15:0] code, bit [6:0] keep);
			case (code)
				16'hFFFE: return 7'h31;
				16'hFFFD: return 7'h32;
				16'hFFFB: return 7'h33;
				16'hFFEF: return 7'h34;
				16'hFFDF: return 7'h35;
				16'hFFBF: return 7'h36;
				16'hFEFF: return 7'h37;
				16'hFDFF: return 7'h38;
				16'hFBFF: return 7'h39;
				16'hEFFF: return 7'h2A;
				16'hDFFF: return 7'h30;
				16'hBFFF: return 7'h23;
				16'h7FFF: return 7'h44;
				16'hF7FF: return 7'h43;
				16'hFF7F: return 7'h42;
				16'hFFF7: return 7'h41;
				default: return keep;
			endcase
		endfunction

		// grades the hold; a short press takes a buffer slot
		function bit [1:0] grade_hold();
			bit [4:0] slots;
			if (hold == 0) return STATUS_NO_HOLD;
			if (hold >= threshold) begin
				hold = 0;
				return STATUS_LONG;
			end
			if (depth == 0) slots = 5'd1;
			else if (depth > MAX_BUFFER_DEPTH) slots = 5'(MAX_BUFFER_DEPTH);
			else slots = depth;
			hold = 0;
			if (wpos >= slots) begin
				wpos = 0;
				wrapped = 1'b1;
			end
			wpos++;
			return STATUS_SHORT;
		endfunction

		function void take_scan(scan_t s);
			result_t r;
			r = '0;
			if (s.mode == MODE_TIMEOUT) begin
				r.press_status = grade_hold();
				if (r.press_status == STATUS_SHORT || r.press_status == STATUS_LONG) begin
					r.event_char = cur_char;
					r.event_code = cur_code;
				end
			end else begin
				cur_code = s.key_bits;
				cur_char = pattern_char(s.key_bits, cur_char);
				if (s.key_bits == RELEASED_CODE) begin
					r.press_status = grade_hold();
					if (r.press_status == STATUS_SHORT || r.press_status == STATUS_LONG) begin
						r.event_char = last_char;
						r.event_code = last_code;
					end
				end else begin
					if (s.key_bits == last_code) begin
						if (hold != HOLD_MAX) hold++;
						r.beep_on = 1'b1;
					end else begin
						hold = 0;
					end
					last_code = s.key_bits;
					last_char = cur_char;
				end
			end
			r.key_char       = cur_char;
			r.buffer_pos     = wpos;
			r.buffer_wrapped = wrapped;
			outcome_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (outcome_q.size() == 0) begin
				$display("%0t: result item with none expected, got %p", $time, got);
				mismatches++;
				return;
			end
			want = outcome_q.pop_front();
			compare_field("key_char", want.key_char, got.key_char);
			compare_field("beep_on", want.beep_on, got.beep_on);
			compare_field("press_status", want.press_status, got.press_status);
			compare_field("event_char", want.event_char, got.event_char);
			compare_field("event_code", want.event_code, got.event_code);
			compare_field("buffer_pos", want.buffer_pos, got.buffer_pos);
			compare_field("buffer_wrapped", want.buffer_wrapped, got.buffer_wrapped);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   idle_on;
	int   hold_req;
	int   hold_left;
	int   sent;
	int   quiet;

	press_tracker tracker = new();

	kplc_cfg_if                   cfg_if();
	kplc_stream_if #(.T(scan_t))   scan_if();
	kplc_stream_if #(.T(result_t)) result_if();

	keypad_press_length_classifier dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.scan   (scan_if),
		.result (result_if)
	);

	always #10 clk = ~clk;

	// result side, with random stalls and a long hold-off on request
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= !(idle_on && $urandom_range(99) < 24);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) tracker.match_result(result_if.data);
	end

	always @(posedge clk) begin
		if ((scan_if.valid && scan_if.ready) || (result_if.valid && result_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("keypad_press_length_classifier: mismatch");
			$finish;
		end
	end

	task automatic push_scan(input logic m, input logic [15:0] bits);
		scan_t item;
		item.mode = m;
		item.key_bits = bits;
		if (idle_on && $urandom_range(99) < 24) begin
			@(negedge clk);
			scan_if.valid <= 1'b0;
			repeat ($urandom_range(2)) @(negedge clk);
		end
		@(negedge clk);
		scan_if.valid <= 1'b1;
		scan_if.data <= item;
		do @(posedge clk); while (scan_if.ready !== 1'b1);
		tracker.take_scan(item);
		sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		scan_if.valid <= 1'b0;
		while (tracker.outcome_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.wdata <= val;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		tracker.set_reg(idx, val);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// one key held for a while, then a release, a timeout or nothing
	task automatic hold_sequence();
		logic [15:0] key;
		int          cap;
		int          n;
		int          ending;
		if ($urandom_range(99) < 10) key = 16'($urandom_range(16'hFFFF));
		else key = KEY_PATTERNS[$urandom_range(KEY_LINES-1)];
		cap = (tracker.threshold >= 12) ? 24 : 2 * tracker.threshold + 1;
		n = $urandom_range(cap);
		repeat (n + 1) begin
			if ($urandom_range(99) < 3) push_scan(MODE_SCAN, 16'($urandom_range(16'hFFFF)));
			push_scan(MODE_SCAN, key);
		end
		ending = $urandom_range(99);
		if (ending < 65) push_scan(MODE_SCAN, RELEASED_CODE);
		else if (ending < 95) push_scan(MODE_TIMEOUT, 16'($urandom_range(16'hFFFF)));
	endtask

	task automatic noise_item();
		case ($urandom_range(3))
			0: push_scan(MODE_SCAN, 16'($urandom_range(16'hFFFF)));
			1: push_scan(MODE_TIMEOUT, 16'($urandom_range(16'hFFFF)));
			2: push_scan(MODE_SCAN, RELEASED_CODE);
			default: push_scan(MODE_SCAN, KEY_PATTERNS[$urandom_range(KEY_LINES-1)]);
		endcase
	endtask

	task automatic run_phase(input logic [15:0] thr, input logic [15:0] dep, input int count,
			input bit squeeze);
		int goal;
		drain_results();
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_DEPTH, dep);
		if (squeeze) hold_req = SINK_HOLDOFF;
		goal = sent + count;
		while (sent < goal) begin
			if ($urandom_range(99) < 70) hold_sequence();
			else noise_item();
			if ($urandom_range(99) < 2) drain_results();
		end
	endtask

	initial begin
		scan_if.valid = 1'b0;
		scan_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.wdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_on = 1'b1;

		// directed items at reset settings
		push_scan(MODE_TIMEOUT, 16'($urandom_range(16'hFFFF)));
		push_scan(MODE_SCAN, RELEASED_CODE);
		push_scan(MODE_SCAN, 16'h0000);
		for (int i = 0; i < KEY_LINES; i++) push_scan(MODE_SCAN, KEY_PATTERNS[i]);
		push_scan(MODE_SCAN, 16'hFFF7);
		push_scan(MODE_SCAN, RELEASED_CODE);
		push_scan(MODE_SCAN, 16'hFFFE);
		push_scan(MODE_SCAN, 16'hFFFE);
		push_scan(MODE_TIMEOUT, 16'h0000);
		push_scan(MODE_TIMEOUT, 16'hFFFF);
		drain_results();

		// long hold, no idling on either side
		write_reg(CFG_THRESHOLD, 16'hFFFF);
		write_reg(CFG_DEPTH, 16'd16);
		idle_on = 1'b0;
		repeat (60) push_scan(MODE_SCAN, 16'hDFFF);
		push_scan(MODE_SCAN, RELEASED_CODE);
		push_scan(MODE_SCAN, 16'hDFFF);
		push_scan(MODE_SCAN, 16'hDFFF);
		push_scan(MODE_TIMEOUT, 16'h5A5A);
		drain_results();
		idle_on = 1'b1;

		run_phase(16'd4, 16'd16, 80, 1'b1);
		run_phase(16'd1, 16'd1, 80, 1'b0);
		run_phase(16'd6, 16'd3, 80, 1'b0);
		run_phase(16'd0, 16'd0, 80, 1'b0);
		run_phase(16'd2, 16'd31, 80, 1'b0);
		run_phase(16'hFFFF, 16'd7, 80, 1'b0);
		run_phase(16'd3, 16'd13, 80, 1'b1);

		drain_results();
		repeat (4) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outcome_q.size() == 0) begin
			$display("keypad_press_length_classifier: match");
		end else begin
			$display("keypad_press_length_classifier: mismatch");
		end
		$finish;
	end

endmodule
